// ===== rtl/core/pvt_pkg.sv =====
// Shared types, constants and the arctangent table of the polygon vertex transform.
`default_nettype none

package pvt_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION   = 3'd6;

    // Datapath widths.
    localparam int unsigned SCALED_W = 41;
    localparam int unsigned ROT_W    = 44;

    // Angle constants in units of 1/65536 degree.
    localparam logic [31:0] DEG360      = 32'd23592960;
    localparam logic [31:0] DEG90       = 32'd5898240;
    localparam logic [31:0] DEG45       = 32'd2949120;
    // Remainder of 2^31 modulo 360 degrees, used to undo the sign-bit offset.
    localparam logic [31:0] WRAP_OFFSET = 32'd524288;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;

    // CORDIC constants, Q1.30 on a 34-bit signed datapath.
    localparam int unsigned CORD_IDX_W = 5;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [33:0] ONE_Q30     = 34'sh040000000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
    } xform_cfg_t;

    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic signed [SCALED_W-1:0] x;
        logic signed [SCALED_W-1:0] y;
        logic                       last;
    } scaled_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic                    last;
    } rotated_t;

    // atan(2^-i) in Q30 radians.
    function automatic logic [31:0] atan_q30(input logic [CORD_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h3243F6A8;
            5'd1:    val = 32'h1DAC6705;
            5'd2:    val = 32'h0FADBAFC;
            5'd3:    val = 32'h07F56EA6;
            5'd4:    val = 32'h03FEAB76;
            5'd5:    val = 32'h01FFD55B;
            5'd6:    val = 32'h00FFFAAA;
            5'd7:    val = 32'h007FFF55;
            5'd8:    val = 32'h003FFFEA;
            5'd9:    val = 32'h001FFFFD;
            5'd10:   val = 32'h000FFFFF;
            5'd11:   val = 32'h0007FFFF;
            5'd12:   val = 32'h0003FFFF;
            5'd13:   val = 32'h0001FFFF;
            5'd14:   val = 32'h0000FFFF;
            5'd15:   val = 32'h00007FFF;
            5'd16:   val = 32'h00003FFF;
            5'd17:   val = 32'h00001FFF;
            5'd18:   val = 32'h00000FFF;
            5'd19:   val = 32'h000007FF;
            5'd20:   val = 32'h000003FF;
            5'd21:   val = 32'h000001FF;
            5'd22:   val = 32'h000000FF;
            5'd23:   val = 32'h0000007F;
            5'd24:   val = 32'h0000003F;
            5'd25:   val = 32'h0000001F;
            5'd26:   val = 32'h0000000F;
            5'd27:   val = 32'h00000008;
            5'd28:   val = 32'h00000004;
            5'd29:   val = 32'h00000002;
            5'd30:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pvt_trig.sv =====
// Sequential sine/cosine unit: angle reduction followed by a rotation-mode CORDIC.
`default_nettype none

module pvt_trig #(
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [31:0]  angle,
    output logic              busy,
    output pvt_pkg::trig_t    trig
);

    localparam int ITER_W = $clog2(CORDIC_STEPS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_WRAP   = 3'd2;
    localparam logic [2:0] ST_QUAD   = 3'd3;
    localparam logic [2:0] ST_RAD    = 3'd4;
    localparam logic [2:0] ST_ITER   = 3'd5;
    localparam logic [2:0] ST_MAP    = 3'd6;

    localparam logic [31:0] DEG135 = 3 * pvt_pkg::DEG45;
    localparam logic [31:0] DEG225 = 5 * pvt_pkg::DEG45;
    localparam logic [31:0] DEG315 = 7 * pvt_pkg::DEG45;
    localparam logic [31:0] DEG180 = 2 * pvt_pkg::DEG90;
    localparam logic [31:0] DEG270 = 3 * pvt_pkg::DEG90;

    logic [2:0]               state_reg, state_next;
    logic [31:0]              rem_reg, rem_next;
    logic [2:0]               k_reg, k_next;
    logic [1:0]               quad_reg, quad_next;
    logic signed [22:0]       d_reg, d_next;
    logic signed [32:0]       z_reg, z_next;
    logic signed [33:0]       x_reg, x_next;
    logic signed [33:0]       y_reg, y_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic signed [31:0]       cos_reg, cos_next;
    logic signed [31:0]       sin_reg, sin_next;

    logic [32:0]              deg_shift;
    logic [32:0]              red_diff;
    logic [31:0]              quad_base;
    logic signed [32:0]       d_wide;
    logic signed [48:0]       z_prod;
    logic signed [48:0]       z_round;
    logic signed [33:0]       x_shr;
    logic signed [33:0]       y_shr;
    logic signed [32:0]       atan_val;
    logic signed [33:0]       cos_map;
    logic signed [33:0]       sin_map;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > pvt_pkg::ONE_Q30) begin
            r = 32'sh40000000;
        end else if (v < -pvt_pkg::ONE_Q30) begin
            r = -32'sh40000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign deg_shift = 33'(pvt_pkg::DEG360) << k_reg;
    assign red_diff  = {1'b0, rem_reg} - deg_shift;
    assign d_wide    = $signed({1'b0, rem_reg}) - $signed({1'b0, quad_base});
    assign z_prod    = d_reg * $signed({1'b0, pvt_pkg::DEG_TO_RAD_Q30});
    assign z_round   = z_prod + 49'sd32768;
    assign x_shr     = x_reg >>> iter_reg;
    assign y_shr     = y_reg >>> iter_reg;
    assign atan_val  = $signed({1'b0, pvt_pkg::atan_q30(iter_reg[pvt_pkg::CORD_IDX_W-1:0])});

    // Nearest quadrant: counts the odd multiples of 45 degrees passed.
    always_comb begin
        if (rem_reg >= DEG315) begin
            quad_next = 2'd0;
            quad_base = pvt_pkg::DEG360;
        end else if (rem_reg >= DEG225) begin
            quad_next = 2'd3;
            quad_base = DEG270;
        end else if (rem_reg >= DEG135) begin
            quad_next = 2'd2;
            quad_base = DEG180;
        end else if (rem_reg >= pvt_pkg::DEG45) begin
            quad_next = 2'd1;
            quad_base = pvt_pkg::DEG90;
        end else begin
            quad_next = 2'd0;
            quad_base = 32'd0;
        end
    end

    always_comb begin
        case (quad_reg)
            2'd1: begin
                cos_map = -y_reg;
                sin_map = x_reg;
            end
            2'd2: begin
                cos_map = -x_reg;
                sin_map = -y_reg;
            end
            2'd3: begin
                cos_map = y_reg;
                sin_map = -x_reg;
            end
            default: begin
                cos_map = x_reg;
                sin_map = y_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        d_next     = d_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        iter_next  = iter_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;

        case (state_reg)
            ST_IDLE: begin
            end
            ST_REDUCE: begin
                if (!red_diff[32]) begin
                    rem_next = red_diff[31:0];
                end
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                // Undo the 2^31 offset applied to make the angle unsigned.
                if (rem_reg < pvt_pkg::WRAP_OFFSET) begin
                    rem_next = rem_reg + pvt_pkg::DEG360 - pvt_pkg::WRAP_OFFSET;
                end else begin
                    rem_next = rem_reg - pvt_pkg::WRAP_OFFSET;
                end
                state_next = ST_QUAD;
            end
            ST_QUAD: begin
                d_next     = d_wide[22:0];
                state_next = ST_RAD;
            end
            ST_RAD: begin
                z_next    = z_round[48:16];
                iter_next = '0;
                y_next    = '0;
                if (d_reg == 23'sd0) begin
                    // Exact multiples of 90 degrees skip the CORDIC.
                    x_next     = pvt_pkg::ONE_Q30;
                    state_next = ST_MAP;
                end else begin
                    x_next     = pvt_pkg::CORDIC_GAIN;
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (!z_reg[32]) begin
                    x_next = x_reg - y_shr;
                    y_next = y_reg + x_shr;
                    z_next = z_reg - atan_val;
                end else begin
                    x_next = x_reg + y_shr;
                    y_next = y_reg - x_shr;
                    z_next = z_reg + atan_val;
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                cos_next   = clamp_q30(cos_map);
                sin_next   = clamp_q30(sin_map);
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (start) begin
            rem_next   = angle ^ 32'h8000_0000;
            k_next     = 3'd7;
            state_next = ST_REDUCE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cos_reg   <= 32'sh40000000;
            sin_reg   <= 32'sd0;
        end else begin
            state_reg <= state_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        k_reg    <= k_next;
        quad_reg <= (state_reg == ST_QUAD) ? quad_next : quad_reg;
        d_reg    <= d_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        iter_reg <= iter_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign trig.cos_v = cos_reg;
    assign trig.sin_v = sin_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pvt_scale.sv =====
// Front pipeline stages: origin subtraction and per-axis scaling with rounding.
`default_nettype none

module pvt_scale (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [31:0]  vertex_x,
    input  wire logic signed [31:0]  vertex_y,
    input  wire logic                last_vertex,
    input  wire pvt_pkg::xform_cfg_t cfg,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pvt_pkg::scaled_t         out_data
);

    logic                 d_vld_reg;
    logic signed [32:0]   dx_reg, dx_next;
    logic signed [32:0]   dy_reg, dy_next;
    logic                 d_last_reg;
    logic                 s_vld_reg;
    pvt_pkg::scaled_t     s_data_reg, s_data_next;
    logic                 d_ready;
    logic                 s_ready;
    logic signed [56:0]   prod_x, prod_y;
    logic signed [56:0]   rnd_x, rnd_y;

    assign s_ready  = !s_vld_reg || out_ready;
    assign d_ready  = !d_vld_reg || s_ready;
    assign in_ready = d_ready;

    assign dx_next = 33'(vertex_x) - 33'(cfg.origin_x);
    assign dy_next = 33'(vertex_y) - 33'(cfg.origin_y);

    assign prod_x = dx_reg * cfg.scale_x;
    assign prod_y = dy_reg * cfg.scale_y;
    assign rnd_x  = prod_x + 57'sd32768;
    assign rnd_y  = prod_y + 57'sd32768;

    always_comb begin
        s_data_next.x    = rnd_x[56:16];
        s_data_next.y    = rnd_y[56:16];
        s_data_next.last = d_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_vld_reg <= in_valid;
            end
            if (s_ready) begin
                s_vld_reg <= d_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            d_last_reg <= last_vertex;
        end
        if (s_ready) begin
            s_data_reg <= s_data_next;
        end
    end

    assign out_valid = s_vld_reg;
    assign out_data  = s_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pvt_rotate.sv =====
// Middle pipeline stages: rotation by the Q1.30 cosine and sine with split products.
`default_nettype none

module pvt_rotate (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pvt_pkg::scaled_t in_data,
    input  wire pvt_pkg::trig_t   trig,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pvt_pkg::rotated_t     out_data
);

    localparam int unsigned HI_W = pvt_pkg::SCALED_W - 16;

    logic signed [HI_W-1:0]  sxh, syh;
    logic signed [16:0]      sxl, syl;

    // Stage A: eight partial products.
    logic                    a_vld_reg;
    logic                    a_last_reg;
    logic signed [56:0]      cxh_reg, cxh_next, sxh_p_reg, sxh_p_next;
    logic signed [56:0]      cyh_reg, cyh_next, syh_p_reg, syh_p_next;
    logic signed [48:0]      cxl_reg, cxl_next, sxl_p_reg, sxl_p_next;
    logic signed [48:0]      cyl_reg, cyl_next, syl_p_reg, syl_p_next;

    // Stage B: high and low sums.
    logic                    b_vld_reg;
    logic                    b_last_reg;
    logic signed [57:0]      hx_reg, hx_next, hy_reg, hy_next;
    logic signed [49:0]      lx_reg, lx_next, ly_reg, ly_next;

    // Stage C: recombined and rounded result.
    logic                    c_vld_reg;
    pvt_pkg::rotated_t       c_data_reg, c_data_next;
    logic signed [73:0]      fx, fy;
    logic signed [73:0]      hx_w, hy_w;

    logic                    a_ready, b_ready, c_ready;

    assign c_ready  = !c_vld_reg || out_ready;
    assign b_ready  = !b_vld_reg || c_ready;
    assign a_ready  = !a_vld_reg || b_ready;
    assign in_ready = a_ready;

    assign sxh = in_data.x[pvt_pkg::SCALED_W-1:16];
    assign syh = in_data.y[pvt_pkg::SCALED_W-1:16];
    assign sxl = $signed({1'b0, in_data.x[15:0]});
    assign syl = $signed({1'b0, in_data.y[15:0]});

    assign cxh_next   = trig.cos_v * sxh;
    assign sxh_p_next = trig.sin_v * sxh;
    assign cyh_next   = trig.cos_v * syh;
    assign syh_p_next = trig.sin_v * syh;
    assign cxl_next   = trig.cos_v * sxl;
    assign sxl_p_next = trig.sin_v * sxl;
    assign cyl_next   = trig.cos_v * syl;
    assign syl_p_next = trig.sin_v * syl;

    assign hx_next = 58'(cxh_reg) - 58'(syh_p_reg);
    assign hy_next = 58'(sxh_p_reg) + 58'(cyh_reg);
    assign lx_next = 50'(cxl_reg) - 50'(syl_p_reg);
    assign ly_next = 50'(sxl_p_reg) + 50'(cyl_reg);

    assign hx_w = {hx_reg, 16'h0000};
    assign hy_w = {hy_reg, 16'h0000};
    assign fx   = hx_w + 74'(lx_reg) + 74'sd536870912;
    assign fy   = hy_w + 74'(ly_reg) + 74'sd536870912;

    always_comb begin
        c_data_next.x    = fx[73:30];
        c_data_next.y    = fy[73:30];
        c_data_next.last = b_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_vld_reg <= in_valid;
            end
            if (b_ready) begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_ready) begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            cxh_reg    <= cxh_next;
            sxh_p_reg  <= sxh_p_next;
            cyh_reg    <= cyh_next;
            syh_p_reg  <= syh_p_next;
            cxl_reg    <= cxl_next;
            sxl_p_reg  <= sxl_p_next;
            cyl_reg    <= cyl_next;
            syl_p_reg  <= syl_p_next;
            a_last_reg <= in_data.last;
        end
        if (b_ready) begin
            hx_reg     <= hx_next;
            hy_reg     <= hy_next;
            lx_reg     <= lx_next;
            ly_reg     <= ly_next;
            b_last_reg <= a_last_reg;
        end
        if (c_ready) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_data  = c_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pvt_place.sv =====
// Output stage: adds position and origin back and saturates to 32 bits.
`default_nettype none

module pvt_place (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pvt_pkg::rotated_t   in_data,
    input  wire pvt_pkg::xform_cfg_t cfg,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       world_x,
    output logic signed [31:0]       world_y,
    output logic                     last_out
);

    localparam logic signed [45:0] SAT_MAX = 46'sd2147483647;
    localparam logic signed [45:0] SAT_MIN = -46'sd2147483648;

    logic                 o_vld_reg;
    logic signed [31:0]   wx_reg, wx_next;
    logic signed [31:0]   wy_reg, wy_next;
    logic                 o_last_reg;
    logic signed [45:0]   sum_x, sum_y;

    assign in_ready = !o_vld_reg || out_ready;

    assign sum_x = 46'(in_data.x) + 46'(cfg.position_x) + 46'(cfg.origin_x);
    assign sum_y = 46'(in_data.y) + 46'(cfg.position_y) + 46'(cfg.origin_y);

    always_comb begin
        if (sum_x > SAT_MAX) begin
            wx_next = 32'sh7FFFFFFF;
        end else if (sum_x < SAT_MIN) begin
            wx_next = 32'sh80000000;
        end else begin
            wx_next = sum_x[31:0];
        end
        if (sum_y > SAT_MAX) begin
            wy_next = 32'sh7FFFFFFF;
        end else if (sum_y < SAT_MIN) begin
            wy_next = 32'sh80000000;
        end else begin
            wy_next = sum_y[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (in_ready) begin
            o_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            wx_reg     <= wx_next;
            wy_reg     <= wy_next;
            o_last_reg <= in_data.last;
        end
    end

    assign out_valid = o_vld_reg;
    assign world_x   = wx_reg;
    assign world_y   = wy_reg;
    assign last_out  = o_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/polygon_vertex_transform_top.sv =====
// Top level of the polygon vertex transform: registers, trig unit and vertex pipeline.
`default_nettype none

// Each vertex beat on the slave side (Q16.16 x and y, plus the last-vertex mark
// on s_tlast) leaves on the master side transformed as: subtract the origin,
// scale each axis by its Q8.16 factor with round-to-nearest, rotate by the
// configured angle with Q1.30 cosine and sine, then add position and origin
// back and saturate to 32 bits. The vertex pipeline has six register stages
// (subtract, scale multiply, rotation products, partial sums, recombine and
// round, place and saturate), and a result is offered on the master side from
// the last of them. One vertex is taken every cycle while s_tready is high;
// each stage holds its beat while the one after it is full, so a stall on
// m_tready fills empty stages before it reaches s_tready. Configuration is
// written through cfg_we, cfg_index and cfg_wdata. A write to the rotation
// register starts the trig unit, which reduces the angle modulo 360 degrees
// in eight steps, then does the wrap, quadrant and radian conversion, runs
// CORDIC_STEPS CORDIC iterations (skipped for multiples of 90 degrees) and
// maps the quadrant; s_tready is low while the trig unit is busy.
module polygon_vertex_transform_top #(
    parameter int CORDIC_STEPS = 30
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Slave side, tdata fields from bit 0: vertex_x[31:0], vertex_y[63:32].
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,
    input  wire logic                           s_tlast,
    // Master side, tdata fields from bit 0: world_x[31:0], world_y[63:32].
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,
    output logic                                m_tlast,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [pvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_wdata
);

    logic signed [31:0]    origin_x_reg;
    logic signed [31:0]    origin_y_reg;
    logic signed [31:0]    position_x_reg;
    logic signed [31:0]    position_y_reg;
    logic signed [23:0]    scale_x_reg;
    logic signed [23:0]    scale_y_reg;

    pvt_pkg::xform_cfg_t   cfg;
    pvt_pkg::trig_t        trig;
    pvt_pkg::scaled_t      scaled;
    pvt_pkg::rotated_t     rotated;

    logic                  trig_start;
    logic                  trig_busy;
    logic                  scale_in_ready;
    logic                  scale_valid, scale_ready;
    logic                  rot_valid, rot_ready;
    logic signed [31:0]    world_x, world_y;

    // Register file. Writes to indexes past the rotation register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= 32'sd0;
            origin_y_reg   <= 32'sd0;
            position_x_reg <= 32'sd0;
            position_y_reg <= 32'sd0;
            scale_x_reg    <= 24'sd65536;
            scale_y_reg    <= 24'sd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                pvt_pkg::CFG_ORIGIN_X:   origin_x_reg   <= cfg_wdata;
                pvt_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= cfg_wdata;
                pvt_pkg::CFG_POSITION_X: position_x_reg <= cfg_wdata;
                pvt_pkg::CFG_POSITION_Y: position_y_reg <= cfg_wdata;
                pvt_pkg::CFG_SCALE_X:    scale_x_reg    <= cfg_wdata[23:0];
                pvt_pkg::CFG_SCALE_Y:    scale_y_reg    <= cfg_wdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.origin_x   = origin_x_reg;
        cfg.origin_y   = origin_y_reg;
        cfg.position_x = position_x_reg;
        cfg.position_y = position_y_reg;
        cfg.scale_x    = scale_x_reg;
        cfg.scale_y    = scale_y_reg;
    end

    // The rotation angle itself is held inside the trig unit while it works.
    assign trig_start = cfg_we && (cfg_index == pvt_pkg::CFG_ROTATION);

    pvt_trig #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (cfg_wdata),
        .busy    (trig_busy),
        .trig    (trig)
    );

    // Vertices are held off while cosine and sine are being recomputed.
    assign s_tready = scale_in_ready && !trig_busy;

    pvt_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid && !trig_busy),
        .in_ready    (scale_in_ready),
        .vertex_x    (s_tdata[31:0]),
        .vertex_y    (s_tdata[63:32]),
        .last_vertex (s_tlast),
        .cfg         (cfg),
        .out_valid   (scale_valid),
        .out_ready   (scale_ready),
        .out_data    (scaled)
    );

    pvt_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scaled),
        .trig      (trig),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rotated)
    );

    pvt_place u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rotated),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .world_x   (world_x),
        .world_y   (world_y),
        .last_out  (m_tlast)
    );

    assign m_tdata = {world_y, world_x};

endmodule

`default_nettype wire

// ===== rtl/core/pvt_checker.sv =====
// Port-level checker for the polygon vertex transform and its bind statement.
`default_nettype none

module pvt_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [63:0]                    m_tdata,
    input wire logic                           m_tlast,
    input wire logic                           cfg_we,
    input wire logic [pvt_pkg::CFG_IDX_W-1:0]  cfg_index
);

    // A held result beat stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // A held result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // A rotation write closes the input while the trig unit recomputes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == pvt_pkg::CFG_ROTATION) |=> !s_tready)
        else $error("vertex input open during trig update");

    // The pipeline comes out of reset empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind polygon_vertex_transform_top pvt_checker u_pvt_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_polygon_vertex_transform_top.sv =====
// Self-checking testbench for the polygon vertex transform top level.
module tb_polygon_vertex_transform_top;

    // The DUT default of 30 CORDIC iterations is used, and the predictor runs the same count.
    localparam int CORDIC_ITERS = 30;

    // Angles are in units of 1/65536 degree.
    localparam int ANG_360 = 23592960;
    localparam int ANG_90  = 5898240;
    localparam int ANG_45  = 2949120;
    localparam longint RAD_PER_DEG_Q30 = 18740330;
    localparam longint CORDIC_K_Q30    = 64'h26DD3B6A;
    localparam longint UNIT_Q30        = 64'h40000000;

    // Register index 7 is not decoded, so a write to it must leave everything unchanged.
    localparam logic [pvt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // The wait before a register write covers the longest trig update
    // and the six-stage vertex pipeline.
    localparam int SETTLE_CYCLES = CORDIC_ITERS + 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;

    // arctan(2^-i) in Q30 radians for each CORDIC iteration.
    localparam longint ARCTAN_Q30 [0:31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } vertex_beat_t;

    typedef struct {
        logic [31:0] wx;
        logic [31:0] wy;
        logic        last;
    } world_vertex_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata   = '0;
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [63:0]                   m_tdata;
    logic                          m_tlast;
    logic                          cfg_we    = 1'b0;
    logic [pvt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_wdata = '0;

    // Vertices waiting to be offered, and the world vertices they must produce, in order.
    vertex_beat_t  pending_q [$];
    world_vertex_t world_q [$];

    // Predictor copy of the configuration and of the cosine and sine registers.
    longint org_x = 0, org_y = 0, pos_x = 0, pos_y = 0;
    longint scl_x = 65536, scl_y = 65536;
    longint cos_q30 = UNIT_Q30, sin_q30 = 0;

    int src_idle_pct  = 11;
    int snk_stall_pct = 48;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    polygon_vertex_transform_top #(
        .CORDIC_STEPS(CORDIC_ITERS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // vertex_x[31:0], vertex_y[63:32]
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // world_x[31:0], world_y[63:32]
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Recompute cosine and sine for a new angle. The angle is folded into
    // [0, 360) degrees, then into a quadrant and a residual within +-45
    // degrees. An exact multiple of 90 degrees skips the CORDIC so that the
    // result is exact; otherwise the residual goes through the CORDIC in
    // rotation mode and the quadrant swaps and negates the pair.
    function automatic void set_rotation(input longint angle);
        longint m, q, d, z, cx, cy, xs, ys, c, s;
        int i;
        m = angle % ANG_360;
        if (m < 0)
            m += ANG_360;
        q = m / ANG_90;
        d = m - q * ANG_90;
        if (d >= ANG_45) begin
            q++;
            d -= ANG_90;
        end
        q &= 3;
        if (d == 0) begin
            c = UNIT_Q30;
            s = 0;
        end else begin
            z  = (d * RAD_PER_DEG_Q30 + 32768) >>> 16;
            cx = CORDIC_K_Q30;
            cy = 0;
            for (i = 0; i < CORDIC_ITERS && i < 32; i++) begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (z >= 0) begin
                    cx -= ys;
                    cy += xs;
                    z  -= ARCTAN_Q30[i];
                end else begin
                    cx += ys;
                    cy -= xs;
                    z  += ARCTAN_Q30[i];
                end
            end
            c = cx;
            s = cy;
        end
        case (q)
            1: begin
                cos_q30 = -s;
                sin_q30 = c;
            end
            2: begin
                cos_q30 = -c;
                sin_q30 = -s;
            end
            3: begin
                cos_q30 = s;
                sin_q30 = -c;
            end
            default: begin
                cos_q30 = c;
                sin_q30 = s;
            end
        endcase
        if (cos_q30 > UNIT_Q30) cos_q30 = UNIT_Q30;
        if (cos_q30 < -UNIT_Q30) cos_q30 = -UNIT_Q30;
        if (sin_q30 > UNIT_Q30) sin_q30 = UNIT_Q30;
        if (sin_q30 < -UNIT_Q30) sin_q30 = -UNIT_Q30;
    endfunction

    // (k1*a + k2*b) / 2^30 rounded to nearest with ties upward. The products
    // need more than 64 bits, so the sum is formed on a 96-bit vector.
    function automatic longint round_q30(input longint k1, input longint a,
                                         input longint k2, input longint b);
        logic signed [95:0] w1, wa, w2, wb, acc;
        w1  = k1;
        wa  = a;
        w2  = k2;
        wb  = b;
        acc = w1 * wa + w2 * wb + 96'sd536870912;
        acc = acc >>> 30;
        return longint'(acc);
    endfunction

    function automatic logic [31:0] saturate32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic world_vertex_t transform_vertex(input logic [31:0] vx,
                                                       input logic [31:0] vy,
                                                       input logic last);
        world_vertex_t res;
        longint lx, ly, sx, sy, rx, ry;
        lx = longint'($signed(vx));
        ly = longint'($signed(vy));
        sx = ((lx - org_x) * scl_x + 32768) >>> 16;
        sy = ((ly - org_y) * scl_y + 32768) >>> 16;
        rx = round_q30(cos_q30, sx, -sin_q30, sy);
        ry = round_q30(sin_q30, sx, cos_q30, sy);
        res.wx   = saturate32(pos_x + rx + org_x);
        res.wy   = saturate32(pos_y + ry + org_y);
        res.last = last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Vertex driver: offers queued vertices on the slave side. A beat stays
    // on the bus until it is taken; only then may a gap or the next beat
    // follow. The expected world vertex is computed at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : vertex_driver
        vertex_beat_t  nxt;
        world_vertex_t exp_w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                exp_w   = transform_vertex(s_tdata[31:0], s_tdata[63:32], s_tlast);
                world_q = {world_q, exp_w};
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.y, nxt.x};
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure on m_tready. A hold request from
    // the stimulus process starts a long stretch with m_tready low, counted
    // here, so that the pipeline fills and s_tready drops.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Every beat taken on the master side is checked against the oldest expectation.
    always @(posedge aclk) begin : result_check
        world_vertex_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (world_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_MAX)
                    $display("unexpected result beat: world_x %h world_y %h last %b",
                             m_tdata[31:0], m_tdata[63:32], m_tlast);
            end else begin
                want = world_q.pop_front();
                if (m_tdata[31:0] !== want.wx || m_tdata[63:32] !== want.wy ||
                    m_tlast !== want.last) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("mismatch: world_x exp %h got %h, world_y exp %h got %h, %s",
                                 want.wx, m_tdata[31:0], want.wy, m_tdata[63:32],
                                 $sformatf("last exp %b got %b", want.last, m_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Waits until no vertex is queued, on the bus or in flight, then lets the
    // trig unit and the pipeline settle before configuration is touched.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || world_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pvt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pvt_pkg::CFG_ORIGIN_X:   org_x = $signed(val);
            pvt_pkg::CFG_ORIGIN_Y:   org_y = $signed(val);
            pvt_pkg::CFG_POSITION_X: pos_x = $signed(val);
            pvt_pkg::CFG_POSITION_Y: pos_y = $signed(val);
            pvt_pkg::CFG_SCALE_X:    scl_x = $signed(val[23:0]);
            pvt_pkg::CFG_SCALE_Y:    scl_y = $signed(val[23:0]);
            pvt_pkg::CFG_ROTATION:   set_rotation($signed(val));
            default: ;
        endcase
    endtask

    task automatic push_vertex(input logic [31:0] x, input logic [31:0] y, input logic last);
        vertex_beat_t beat;
        beat.x    = x;
        beat.y    = y;
        beat.last = last;
        pending_q = {pending_q, beat};
    endtask

    // A coordinate with a spread of magnitudes: extremes, full-range values
    // and values shifted down so that many results stay clear of saturation.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return $urandom();
            default: return $signed($urandom()) >>> $urandom_range(4, 28);
        endcase
    endfunction

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 24'($urandom());
            1: return 24'd65536;
            2: return 24'd65536 + 24'($urandom_range(0, 8192)) - 24'd4096;
            3: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            default: return 24'($signed($urandom()) >>> $urandom_range(8, 14));
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        int k;
        k = $urandom_range(0, 40) - 20;
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return k * ANG_90;
            3: return k * ANG_90 + ANG_45;
            4: return k * ANG_90 + ANG_45 - 1;
            default: return $urandom_range(0, 2 * ANG_90) - ANG_90;
        endcase
    endfunction

    // A fresh configuration: every register gets a new value, and now and
    // then the undecoded index is written as well.
    task automatic random_setup();
        write_reg(pvt_pkg::CFG_ORIGIN_X, rand_coord());
        write_reg(pvt_pkg::CFG_ORIGIN_Y, rand_coord());
        write_reg(pvt_pkg::CFG_POSITION_X, rand_coord());
        write_reg(pvt_pkg::CFG_POSITION_Y, rand_coord());
        write_reg(pvt_pkg::CFG_SCALE_X, {8'($urandom()), rand_scale()});
        write_reg(pvt_pkg::CFG_SCALE_Y, {8'($urandom()), rand_scale()});
        write_reg(pvt_pkg::CFG_ROTATION, rand_angle());
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, $urandom());
    endtask

    // Puts the identity transform back, then sets only the angle.
    task automatic rotation_only(input logic [31:0] angle);
        write_reg(pvt_pkg::CFG_ORIGIN_X, 32'd0);
        write_reg(pvt_pkg::CFG_ORIGIN_Y, 32'd0);
        write_reg(pvt_pkg::CFG_POSITION_X, 32'd0);
        write_reg(pvt_pkg::CFG_POSITION_Y, 32'd0);
        write_reg(pvt_pkg::CFG_SCALE_X, 32'd65536);
        write_reg(pvt_pkg::CFG_SCALE_Y, 32'd65536);
        write_reg(pvt_pkg::CFG_ROTATION, angle);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned setup, n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration is the identity, and unit scale must give the input back.
        push_vertex(32'h0000_0000, 32'h0000_0000, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_vertex(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        push_vertex(32'h0001_0000, 32'hFFFF_8000, 1'b0);

        // Extreme registers: the widest intermediates, with only the final sums saturating.
        write_reg(pvt_pkg::CFG_SCALE_X, 32'h007F_FFFF);
        write_reg(pvt_pkg::CFG_SCALE_Y, 32'hFF80_0000);
        write_reg(pvt_pkg::CFG_ORIGIN_X, 32'h8000_0000);
        write_reg(pvt_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(pvt_pkg::CFG_POSITION_X, 32'h7FFF_FFFF);
        write_reg(pvt_pkg::CFG_POSITION_Y, 32'h8000_0000);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_vertex(32'h0000_0000, 32'h0000_0000, 1'b1);

        // Multiples of 90 degrees are exact, with no CORDIC error.
        rotation_only(ANG_90);
        push_vertex(32'h0001_0000, 32'h0002_0000, 1'b0);
        push_vertex(32'hFFFD_0000, 32'h0000_5000, 1'b1);
        write_reg(pvt_pkg::CFG_ROTATION, 2 * ANG_90);
        push_vertex(32'h0003_8000, 32'hFFFF_0001, 1'b0);
        write_reg(pvt_pkg::CFG_ROTATION, -ANG_90);
        push_vertex(32'h0003_8000, 32'hFFFF_0001, 1'b1);
        write_reg(pvt_pkg::CFG_ROTATION, 3 * ANG_360);
        push_vertex(32'h1234_5678, 32'hEDCB_A988, 1'b0);

        // A residual of exactly 45 degrees moves to the next quadrant.
        write_reg(pvt_pkg::CFG_ROTATION, ANG_45);
        push_vertex(32'h0010_0000, 32'h0000_0000, 1'b1);
        write_reg(pvt_pkg::CFG_ROTATION, -ANG_45);
        push_vertex(32'h0010_0000, 32'h0010_0000, 1'b0);

        // The most extreme angles still reduce modulo 360 degrees.
        write_reg(pvt_pkg::CFG_ROTATION, 32'h7FFF_FFFF);
        push_vertex(32'h0100_0000, 32'hFF00_0000, 1'b1);
        write_reg(pvt_pkg::CFG_ROTATION, 32'h8000_0000);
        push_vertex(32'h0100_0000, 32'hFF00_0000, 1'b0);

        // A write to the undecoded index must change nothing.
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        push_vertex(32'h0100_0000, 32'hFF00_0000, 1'b1);

        // Random part: twelve configurations of a hundred vertices each. The
        // first third lets the sender idle a little and the receiver a lot,
        // the second third the other way round, the last third runs flat out.
        for (setup = 0; setup < 12; setup++) begin
            if (setup == 4) begin
                src_idle_pct  <= 48;
                snk_stall_pct <= 11;
            end else if (setup == 8) begin
                src_idle_pct  <= 0;
                snk_stall_pct <= 0;
            end
            random_setup();
            for (n = 0; n < 100; n++) begin
                // Long receiver hold-off while the sender keeps offering.
                if (setup == 1 && n == 40)
                    hold_req <= hold_req + 1;
                // The sender pauses here until every expected result has come back.
                if (setup == 5 && n == 50)
                    wait_drained();
                push_vertex(rand_coord(), rand_coord(), $urandom_range(0, 3) == 0);
            end
        end

        while (pending_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        n = 0;
        while (world_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (world_q.size() != 0) begin
            $display("%0d expected result beats never arrived", world_q.size());
            err_cnt += world_q.size();
        end

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge aclk);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pvt_pkg.sv
rtl/core/pvt_trig.sv
rtl/core/pvt_scale.sv
rtl/core/pvt_rotate.sv
rtl/core/pvt_place.sv
rtl/core/polygon_vertex_transform_top.sv
rtl/core/pvt_checker.sv
tb/sv/tb_polygon_vertex_transform_top.sv
